// ===== src/dllt_pkg.sv =====
// Shared types, constants and saturating arithmetic for the delay-locked loop tracker.
`timescale 1ns / 1ps

package dllt_pkg;

   localparam int VAL_W     = 48;
   localparam int GAIN_W    = 18;
   localparam int MAX_ORDER = 4;
   localparam int NODE_AW   = $clog2(MAX_ORDER);
   localparam int ORDER_W   = 3;
   localparam int CMD_W     = 2;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = GAIN_W;
   localparam int FRAC_W    = 16;
   localparam int MUL_A_W   = VAL_W - FRAC_W;
   localparam int PROD_W    = MUL_A_W + GAIN_W;
   localparam int LOW_W     = GAIN_W + 1;
   localparam int SUM_W     = PROD_W + 1;

   typedef logic signed [VAL_W-1:0]  value_type;
   typedef logic signed [GAIN_W-1:0] gain_type;

   localparam value_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam value_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [CMD_W-1:0] CMD_FEED   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PRESET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_LOOP_ORDER = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_GAIN_0     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_GAIN_1     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_GAIN_2     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_GAIN_3     = 3'd4;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    clip;
   } sat_type;

   typedef struct packed {
      logic lo_step;
      logic hi_step;
   } mul_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ERR,
      ST_MLO,
      ST_MHI,
      ST_ADD,
      ST_LINK,
      ST_WB,
      ST_RDN,
      ST_OUTN,
      ST_DONE
   } state_type;

   function automatic sat_type sat_fix(logic [VAL_W:0] sum);
      sat_type r;
      if (sum[VAL_W] != sum[VAL_W-1]) begin
         r.clip  = 1'b1;
         r.value = sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         r.clip  = 1'b0;
         r.value = sum[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic sat_type sat_add(value_type a, value_type b);
      logic [VAL_W:0] sum;
      sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      return sat_fix(sum);
   endfunction

   function automatic sat_type sat_sub(value_type a, value_type b);
      logic [VAL_W:0] diff;
      diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      return sat_fix(diff);
   endfunction

   // Index of the highest active integrator for a given order setting.
   function automatic logic [NODE_AW-1:0] last_node(logic [ORDER_W-1:0] order);
      logic [NODE_AW-1:0] r;
      if (order == '0) begin
         r = '0;
      end else if (order > ORDER_W'(MAX_ORDER)) begin
         r = NODE_AW'(MAX_ORDER - 1);
      end else begin
         r = NODE_AW'(order - ORDER_W'(1));
      end
      return r;
   endfunction

endpackage

// ===== src/delay_locked_loop_tracker.sv =====
// Top level of the delay-locked loop tracker: sequencer, node memory and multiplier.
//
//   Channel  Direction  Handshake                   Payload
//   req      in         req_valid / req_stall       command, sample_value, node_index
//   rsp      out        rsp_valid / rsp_stall       loop_output, loop_error, saturated
//   csr      in         csr_write_enable            csr_index, csr_write_data
//
// A feed passes every integrator of the active order N once through the shared two-step
// multiplier and the node memory. Preset, clear and the unused command go through ST_EXEC,
// ST_RDN, ST_OUTN and ST_DONE instead.
// Reset is synchronous; the nodes read as zero after reset through per-entry valid bits.
// The result register lets the next item be accepted while a result waits on rsp_stall.
`timescale 1ns / 1ps

module delay_locked_loop_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dllt_pkg::CMD_W-1:0]        req_command,
   input  logic signed [dllt_pkg::VAL_W-1:0] req_sample_value,
   input  logic [dllt_pkg::NODE_AW-1:0]      req_node_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [dllt_pkg::VAL_W-1:0] rsp_loop_output,
   output logic signed [dllt_pkg::VAL_W-1:0] rsp_loop_error,
   output logic                              rsp_saturated,
   input  logic                              csr_write_enable,
   input  logic [dllt_pkg::CSR_AW-1:0]       csr_index,
   input  logic [dllt_pkg::CSR_DW-1:0]       csr_write_data
);

   dllt_pkg::state_type state_ff;
   dllt_pkg::state_type state_in;

   logic [dllt_pkg::ORDER_W-1:0] order_ff;
   dllt_pkg::gain_type           gain_ff [dllt_pkg::MAX_ORDER];
   logic [dllt_pkg::MAX_ORDER-1:0] vld_ff;
   logic                         rd_vld_ff;

   logic [dllt_pkg::CMD_W-1:0]   cmd_ff;
   dllt_pkg::value_type          sample_ff;
   logic [dllt_pkg::NODE_AW-1:0] node_sel_ff;
   logic [dllt_pkg::NODE_AW-1:0] idx_ff;
   dllt_pkg::value_type          err_ff;
   dllt_pkg::value_type          acc_ff;
   dllt_pkg::value_type          nxt_ff;
   dllt_pkg::value_type          out_node_ff;
   logic                         clip_ff;

   logic                         rsp_valid_ff;
   dllt_pkg::value_type          rsp_output_ff;
   dllt_pkg::value_type          rsp_error_ff;
   logic                         rsp_sat_ff;

   logic                         ram_we;
   logic [dllt_pkg::NODE_AW-1:0] ram_waddr;
   dllt_pkg::value_type          ram_wdata;
   logic [dllt_pkg::NODE_AW-1:0] ram_raddr;
   dllt_pkg::value_type          ram_rdata;
   dllt_pkg::value_type          node_rd;

   dllt_pkg::mul_ctl_type        mul_ctl;
   dllt_pkg::value_type          mul_value;
   logic                         mul_clip;

   logic [dllt_pkg::NODE_AW-1:0] last_idx;
   logic                         req_xfer;
   logic                         rsp_free;
   logic                         clear_nodes;
   dllt_pkg::sat_type            err_sum;
   dllt_pkg::sat_type            add_sum;
   dllt_pkg::sat_type            link_sum;

   localparam logic [dllt_pkg::NODE_AW-1:0] NODE_AW_ONE = dllt_pkg::NODE_AW'(1);

   assign last_idx    = dllt_pkg::last_node(order_ff);
   assign req_stall   = (state_ff != dllt_pkg::ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign node_rd     = rd_vld_ff ? ram_rdata : '0;
   assign err_sum     = dllt_pkg::sat_sub(sample_ff, node_rd);
   assign add_sum     = dllt_pkg::sat_add(acc_ff, mul_value);
   assign link_sum    = dllt_pkg::sat_add(acc_ff, nxt_ff);
   assign clear_nodes = (csr_write_enable && csr_index == dllt_pkg::CSR_LOOP_ORDER)
                     || (state_ff == dllt_pkg::ST_EXEC && cmd_ff == dllt_pkg::CMD_CLEAR);

   dllt_node_ram u_node_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   dllt_gain_mul u_gain_mul (
      .clock        (clock),
      .ctl          (mul_ctl),
      .error_value  (err_ff),
      .gain         (gain_ff[idx_ff]),
      .product      (mul_value),
      .product_clip (mul_clip)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dllt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = acc_ff;
      ram_raddr = '0;
      mul_ctl   = '0;
      unique case (state_ff)
         dllt_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = dllt_pkg::ST_EXEC;
            end
         end
         dllt_pkg::ST_EXEC: begin
            if (cmd_ff == dllt_pkg::CMD_FEED) begin
               state_in = dllt_pkg::ST_ERR;
            end else begin
               state_in = dllt_pkg::ST_RDN;
               if (cmd_ff == dllt_pkg::CMD_PRESET && node_sel_ff <= last_idx) begin
                  ram_we    = 1'b1;
                  ram_waddr = node_sel_ff;
                  ram_wdata = sample_ff;
               end
            end
         end
         dllt_pkg::ST_ERR: begin
            state_in = dllt_pkg::ST_MLO;
         end
         dllt_pkg::ST_MLO: begin
            mul_ctl.lo_step = 1'b1;
            ram_raddr       = idx_ff + NODE_AW_ONE;
            state_in        = dllt_pkg::ST_MHI;
         end
         dllt_pkg::ST_MHI: begin
            mul_ctl.hi_step = 1'b1;
            state_in        = dllt_pkg::ST_ADD;
         end
         dllt_pkg::ST_ADD: begin
            state_in = (idx_ff != last_idx) ? dllt_pkg::ST_LINK : dllt_pkg::ST_WB;
         end
         dllt_pkg::ST_LINK: begin
            ram_we    = 1'b1;
            ram_wdata = link_sum.value;
            state_in  = dllt_pkg::ST_MLO;
         end
         dllt_pkg::ST_WB: begin
            ram_we   = 1'b1;
            state_in = dllt_pkg::ST_DONE;
         end
         dllt_pkg::ST_RDN: begin
            state_in = dllt_pkg::ST_OUTN;
         end
         dllt_pkg::ST_OUTN: begin
            state_in = dllt_pkg::ST_DONE;
         end
         dllt_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = dllt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dllt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= dllt_pkg::ORDER_RESET;
         for (int i = 0; i < dllt_pkg::MAX_ORDER; i++) begin
            gain_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dllt_pkg::CSR_LOOP_ORDER: order_ff   <= csr_write_data[dllt_pkg::ORDER_W-1:0];
            dllt_pkg::CSR_GAIN_0:     gain_ff[0] <= csr_write_data;
            dllt_pkg::CSR_GAIN_1:     gain_ff[1] <= csr_write_data;
            dllt_pkg::CSR_GAIN_2:     gain_ff[2] <= csr_write_data;
            dllt_pkg::CSR_GAIN_3:     gain_ff[3] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (clear_nodes) begin
         vld_ff <= '0;
      end else if (ram_we) begin
         vld_ff[ram_waddr] <= 1'b1;
      end
      rd_vld_ff <= vld_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
      end else if (state_ff == dllt_pkg::ST_ERR) begin
         err_ff <= err_sum.value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff      <= req_command;
         sample_ff   <= req_sample_value;
         node_sel_ff <= req_node_index;
      end
      case (state_ff)
         dllt_pkg::ST_EXEC: begin
            clip_ff <= 1'b0;
         end
         dllt_pkg::ST_ERR: begin
            clip_ff <= err_sum.clip;
            acc_ff  <= node_rd;
            idx_ff  <= '0;
         end
         dllt_pkg::ST_MHI: begin
            nxt_ff <= node_rd;
         end
         dllt_pkg::ST_ADD: begin
            acc_ff  <= add_sum.value;
            clip_ff <= clip_ff | mul_clip | add_sum.clip;
         end
         dllt_pkg::ST_LINK: begin
            if (idx_ff == '0) begin
               out_node_ff <= link_sum.value;
            end
            clip_ff <= clip_ff | link_sum.clip;
            acc_ff  <= nxt_ff;
            idx_ff  <= idx_ff + NODE_AW_ONE;
         end
         dllt_pkg::ST_WB: begin
            if (idx_ff == '0) begin
               out_node_ff <= acc_ff;
            end
         end
         dllt_pkg::ST_OUTN: begin
            out_node_ff <= node_rd;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == dllt_pkg::ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == dllt_pkg::ST_DONE && rsp_free) begin
         rsp_output_ff <= out_node_ff;
         rsp_error_ff  <= err_ff;
         rsp_sat_ff    <= clip_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_loop_output = rsp_output_ff;
   assign rsp_loop_error  = rsp_error_ff;
   assign rsp_saturated   = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == dllt_pkg::ST_EXEC)
      else $error("accepted transfer did not start execution");

   a_ram_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == dllt_pkg::ST_EXEC || state_ff == dllt_pkg::ST_LINK
                  || state_ff == dllt_pkg::ST_WB))
      else $error("node memory written outside a write step");

   a_link_in_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == dllt_pkg::ST_LINK |-> idx_ff != last_idx)
      else $error("link step beyond the active order");

   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_ctl.lo_step, mul_ctl.hi_step}))
      else $error("both multiplier steps requested together");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dllt_pkg::ST_DONE))
      else $error("result transfer raised outside the completion step");
`endif

endmodule

// ===== src/dllt_node_ram.sv =====
// Integrator node memory with one write port and one registered read port.
`timescale 1ns / 1ps

module dllt_node_ram (
   input  logic                             clock,
   input  logic                             write_enable,
   input  logic [dllt_pkg::NODE_AW-1:0]     write_addr,
   input  dllt_pkg::value_type              write_data,
   input  logic [dllt_pkg::NODE_AW-1:0]     read_addr,
   output dllt_pkg::value_type              read_data
);

   dllt_pkg::value_type mem [dllt_pkg::MAX_ORDER];
   dllt_pkg::value_type read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/dllt_gain_mul.sv =====
// Two-step error times gain multiplier with rounding and saturation to 48 bits.
`timescale 1ns / 1ps

module dllt_gain_mul (
   input  logic                  clock,
   input  dllt_pkg::mul_ctl_type ctl,
   input  dllt_pkg::value_type   error_value,
   input  dllt_pkg::gain_type    gain,
   output dllt_pkg::value_type   product,
   output logic                  product_clip
);

   logic signed [dllt_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dllt_pkg::PROD_W-1:0]  mul_p;
   logic signed [dllt_pkg::PROD_W-1:0]  rnd;
   logic signed [dllt_pkg::LOW_W-1:0]   low_ff;
   logic signed [dllt_pkg::LOW_W-1:0]   low_in;
   logic signed [dllt_pkg::SUM_W-1:0]   sum_ff;
   logic signed [dllt_pkg::SUM_W-1:0]   sum_in;
   logic [dllt_pkg::SUM_W-dllt_pkg::VAL_W:0] top_bits;

   // The low step multiplies the unsigned fraction bits, the high step the signed upper bits.
   assign mul_a = ctl.lo_step
      ? $signed({{(dllt_pkg::MUL_A_W-dllt_pkg::FRAC_W){1'b0}},
                 error_value[dllt_pkg::FRAC_W-1:0]})
      : $signed(error_value[dllt_pkg::VAL_W-1:dllt_pkg::FRAC_W]);
   assign mul_p  = mul_a * gain;
   assign rnd    = mul_p + dllt_pkg::PROD_W'(1 << (dllt_pkg::FRAC_W - 1));
   assign low_in = rnd[dllt_pkg::FRAC_W+dllt_pkg::LOW_W-1:dllt_pkg::FRAC_W];
   assign sum_in = dllt_pkg::SUM_W'(mul_p) + dllt_pkg::SUM_W'(low_ff);

   always_ff @(posedge clock) begin
      if (ctl.lo_step) begin
         low_ff <= low_in;
      end
      if (ctl.hi_step) begin
         sum_ff <= sum_in;
      end
   end

   assign top_bits     = sum_ff[dllt_pkg::SUM_W-1:dllt_pkg::VAL_W-1];
   assign product_clip = !((&top_bits) || !(|top_bits));
   assign product      = !product_clip ? sum_ff[dllt_pkg::VAL_W-1:0]
                       : (sum_ff[dllt_pkg::SUM_W-1] ? dllt_pkg::VAL_MIN : dllt_pkg::VAL_MAX);

endmodule
